// ===== rtl/nssd_pkg.sv =====
`timescale 1ns / 1ps

package nssd_pkg;

    localparam int LEN_BITS_DEFAULT = 16;

    localparam int HEADER_BYTES = 8;
    localparam int HDR_POS_BITS = 3;
    localparam logic [HDR_POS_BITS-1:0] HDR_ROT_POS = 3'd3;
    localparam logic [HDR_POS_BITS-1:0] HDR_LEN_POS = 3'd4;
    localparam logic [HDR_POS_BITS-1:0] HDR_LAST_POS = 3'(HEADER_BYTES - 1);

    localparam logic [1:0] GRP_LAST_IDX = 2'd3;

    localparam logic [7:0] ROT_MASK = 8'h30;
    localparam logic [7:0] LO_NIB = 8'h0F;
    localparam logic [7:0] HI_NIB = 8'hF0;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_TRAILER = 1'b1;

    localparam int OUT_TDATA_BITS = 16;

    typedef logic [7:0] t_byte;

endpackage

// ===== rtl/nibble_scramble_string_decoder.sv =====
`timescale 1ns / 1ps
// Channel   Dir  tdata                          tuser      tlast
// s_axis    in   [7:0] data_byte                -          -
// m_axis    out  [7:0] char_value, [8] check_ok [0] kind   last
//
// One byte per cycle sustained while the output is not stalled; each accepted byte
// is held in the input register, then any result it yields goes to the result register.
// Reset (synchronous, i_rst_n low) returns to the start of a frame.
// A stalled result holds the output register; the input register keeps
// accepting until both stages are full.

module nibble_scramble_string_decoder #(
    parameter int LEN_BITS = nssd_pkg::LEN_BITS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [7:0]                          i_s_axis_tdata,  // [7:0] data_byte
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [nssd_pkg::OUT_TDATA_BITS-1:0] o_m_axis_tdata,  // [7:0] char_value, [8] check_ok
    output logic                                o_m_axis_tuser,  // [0] kind
    output logic                                o_m_axis_tlast
);

    logic                 r_in_valid;
    nssd_pkg::t_byte      r_in_byte;

    logic                 r_in_hdr, n_in_hdr;
    logic [nssd_pkg::HDR_POS_BITS-1:0] r_hdr_pos, n_hdr_pos;
    logic [1:0]           r_grp_idx, n_grp_idx;
    logic [LEN_BITS-1:0]  r_count, n_count;
    logic [1:0]           r_rot, n_rot;
    nssd_pkg::t_byte      r_grp0, r_grp1, r_grp2;

    logic                 r_out_valid;
    logic                 r_out_kind;
    nssd_pkg::t_byte      r_out_char;
    logic                 r_out_ok;
    logic                 r_out_last;

    logic                 out_free;
    logic                 advance;
    logic                 emit;
    logic                 is_trailer;
    logic [LEN_BITS+3:0]  len_shift;
    nssd_pkg::t_byte      dec_char;
    logic [1:0]           byte_rot;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    assign len_shift = {r_count, r_in_byte[3:0]};
    assign byte_rot  = 2'((r_in_byte & nssd_pkg::ROT_MASK) >> 4);
    assign emit       = !r_in_hdr && (r_grp_idx == nssd_pkg::GRP_LAST_IDX);
    assign is_trailer = emit && (r_count == '0);

    nssd_char_mux u_char_mux (
        .i_grp0 (r_grp0),
        .i_grp1 (r_grp1),
        .i_grp2 (r_grp2),
        .i_cur  (r_in_byte),
        .i_rot  (r_rot),
        .o_char (dec_char)
    );

    always_comb begin
        n_in_hdr  = r_in_hdr;
        n_hdr_pos = r_hdr_pos;
        n_grp_idx = r_grp_idx;
        n_count   = r_count;
        n_rot     = r_rot;
        if (r_in_hdr) begin
            n_hdr_pos = r_hdr_pos + 1'b1;
            if (r_hdr_pos == nssd_pkg::HDR_ROT_POS) begin
                n_rot = byte_rot;
            end else if (r_hdr_pos >= nssd_pkg::HDR_LEN_POS) begin
                n_count = len_shift[LEN_BITS-1:0];
            end
            if (r_hdr_pos == nssd_pkg::HDR_LAST_POS) begin
                n_in_hdr  = 1'b0;
                n_grp_idx = '0;
            end
        end else if (!emit) begin
            n_grp_idx = r_grp_idx + 1'b1;
        end else if (!is_trailer) begin
            n_grp_idx = '0;
            n_rot     = r_rot + 1'b1;
            n_count   = r_count - 1'b1;
        end else begin
            n_in_hdr  = 1'b1;
            n_hdr_pos = '0;
            n_grp_idx = '0;
            n_count   = '0;
            n_rot     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_in_hdr    <= 1'b1;
            r_hdr_pos   <= '0;
            r_grp_idx   <= '0;
            r_count     <= '0;
            r_rot       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_in_hdr    <= n_in_hdr;
                r_hdr_pos   <= n_hdr_pos;
                r_grp_idx   <= n_grp_idx;
                r_count     <= n_count;
                r_rot       <= n_rot;
                r_out_valid <= emit;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (advance && !r_in_hdr) begin
            case (r_grp_idx)
                2'd0:    r_grp0 <= r_in_byte;
                2'd1:    r_grp1 <= r_in_byte;
                2'd2:    r_grp2 <= r_in_byte;
                default: ;
            endcase
        end
        if (advance && emit) begin
            r_out_kind <= is_trailer ? nssd_pkg::KIND_TRAILER : nssd_pkg::KIND_CHAR;
            r_out_char <= is_trailer ? 8'h00 : dec_char;
            r_out_ok   <= is_trailer && (byte_rot == r_rot);
            r_out_last <= is_trailer;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(nssd_pkg::OUT_TDATA_BITS - 9){1'b0}}, r_out_ok, r_out_char};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    // trailer result carries no character and always closes the frame
    a_trailer_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == nssd_pkg::KIND_TRAILER)
        |-> (o_m_axis_tlast && o_m_axis_tdata[7:0] == 8'h00))
        else $error("trailer result malformed");

    // characters never carry last or check_ok
    a_char_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == nssd_pkg::KIND_CHAR)
        |-> (!o_m_axis_tlast && !o_m_axis_tdata[8]))
        else $error("character result malformed");

    // a trailer returns the decoder to the start of a frame
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_trailer)
        |=> (r_in_hdr && r_hdr_pos == '0 && r_count == '0 && r_rot == '0))
        else $error("frame state not cleared after trailer");

    // a pending result is never overwritten while stalled
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !advance)
        else $error("result register overrun");

endmodule

// ===== rtl/nssd_char_mux.sv =====
`timescale 1ns / 1ps

module nssd_char_mux (
    input  nssd_pkg::t_byte i_grp0,
    input  nssd_pkg::t_byte i_grp1,
    input  nssd_pkg::t_byte i_grp2,
    input  nssd_pkg::t_byte i_cur,
    input  logic [1:0]      i_rot,
    output nssd_pkg::t_byte o_char
);

    nssd_pkg::t_byte lo_src;
    nssd_pkg::t_byte hi_src;

    // low nibble from byte 3-rot, high nibble from byte 3-((rot+2) mod 4)
    always_comb begin
        case (i_rot)
            2'd0: begin
                lo_src = i_cur;
                hi_src = i_grp1;
            end
            2'd1: begin
                lo_src = i_grp2;
                hi_src = i_grp0;
            end
            2'd2: begin
                lo_src = i_grp1;
                hi_src = i_cur;
            end
            default: begin
                lo_src = i_grp0;
                hi_src = i_grp2;
            end
        endcase
    end

    assign o_char = (lo_src & nssd_pkg::LO_NIB) | (hi_src & nssd_pkg::HI_NIB);

endmodule

// ===== tb/nssd_result_checker.sv =====
`timescale 1ns / 1ps

module nssd_result_checker
    import nssd_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    input  logic                       i_s_axis_tready,
    input  logic [7:0]                 i_s_axis_tdata,  // [7:0] data_byte
    input  logic                       i_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    input  logic [OUT_TDATA_BITS-1:0]  i_m_axis_tdata,  // [7:0] char_value, [8] check_ok
    input  logic                       i_m_axis_tuser,  // [0] kind
    input  logic                       i_m_axis_tlast,
    output int                         o_pending,
    output int                         o_mismatch_count
);

    typedef struct packed {
        logic       kind;
        logic [7:0] char_value;
        logic       check_ok;
        logic       last;
    } t_decoded;

    logic [18:0]         frame_pos;
    logic [LEN_BITS-1:0] chars_left;
    logic [1:0]          rot;
    t_byte               grp [3];
    t_decoded            decoded_q [$];
    int                  mismatch_count = 0;

    assign o_mismatch_count = mismatch_count;

    initial o_pending = 0;

    function automatic t_byte group_src(input logic [1:0] idx, input t_byte cur);
        return (idx == GRP_LAST_IDX) ? cur : grp[idx];
    endfunction

    task automatic decode_byte(input t_byte b);
        logic [1:0] k;
        logic [1:0] lo_idx;
        logic [1:0] hi_idx;
        t_decoded   r;
        k = 2'(frame_pos - HEADER_BYTES);
        if (frame_pos < HEADER_BYTES) begin
            if (frame_pos == HDR_ROT_POS) begin
                rot = 2'((b & ROT_MASK) >> 4);
            end else if (frame_pos >= HDR_LEN_POS) begin
                chars_left = LEN_BITS'({chars_left, 4'(b & LO_NIB)});
            end
            frame_pos = frame_pos + 1'b1;
        end else if (k != GRP_LAST_IDX) begin
            grp[k] = b;
            frame_pos = frame_pos + 1'b1;
        end else if (chars_left != '0) begin
            lo_idx = GRP_LAST_IDX - rot;
            hi_idx = GRP_LAST_IDX - 2'(rot + 2'd2);
            r.kind = KIND_CHAR;
            r.char_value = (group_src(lo_idx, b) & LO_NIB) | (group_src(hi_idx, b) & HI_NIB);
            r.check_ok = 1'b0;
            r.last = 1'b0;
            decoded_q.push_back(r);
            rot = rot + 1'b1;
            chars_left = chars_left - 1'b1;
            frame_pos = frame_pos + 1'b1;
        end else begin
            r.kind = KIND_TRAILER;
            r.char_value = 8'h00;
            r.check_ok = (2'((b & ROT_MASK) >> 4) == rot);
            r.last = 1'b1;
            decoded_q.push_back(r);
            frame_pos = '0;
            chars_left = '0;
            rot = '0;
        end
    endtask

    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            frame_pos = '0;
            chars_left = '0;
            rot = '0;
            decoded_q.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                decode_byte(i_s_axis_tdata);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected transaction: kind %0b tdata %h last %0b",
                           i_m_axis_tuser, i_m_axis_tdata, i_m_axis_tlast);
                    mismatch_count++;
                end else begin
                    want = decoded_q.pop_front();
                    if (i_m_axis_tuser !== want.kind) begin
                        $error("kind: expected %0b, got %0b", want.kind, i_m_axis_tuser);
                        mismatch_count++;
                    end
                    if (i_m_axis_tdata[7:0] !== want.char_value) begin
                        $error("char_value: expected %h, got %h",
                               want.char_value, i_m_axis_tdata[7:0]);
                        mismatch_count++;
                    end
                    if (i_m_axis_tdata[8] !== want.check_ok) begin
                        $error("check_ok: expected %0b, got %0b",
                               want.check_ok, i_m_axis_tdata[8]);
                        mismatch_count++;
                    end
                    if (i_m_axis_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_m_axis_tlast);
                        mismatch_count++;
                    end
                end
            end
        end
        o_pending <= decoded_q.size();
    end

endmodule

// ===== tb/nibble_scramble_string_decoder_tb.sv =====
`timescale 1ns / 1ps

module nibble_scramble_string_decoder_tb;
    import nssd_pkg::*;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      s_valid = 1'b0;
    t_byte                     s_data = 8'h00;
    logic                      s_ready;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_data;
    logic                      m_user;
    logic                      m_last;
    int                        pending;
    int                        mismatches;

    int bytes_sent = 0;
    int burst_left = 0;

    nibble_scramble_string_decoder dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    nssd_result_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_s_axis_tvalid  (s_valid),
        .i_s_axis_tready  (s_ready),
        .i_s_axis_tdata   (s_data),
        .i_m_axis_tvalid  (m_valid),
        .i_m_axis_tready  (m_ready),
        .i_m_axis_tdata   (m_data),
        .i_m_axis_tuser   (m_user),
        .i_m_axis_tlast   (m_last),
        .o_pending        (pending),
        .o_mismatch_count (mismatches)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic push_byte(input t_byte b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge clk);
                s_valid <= 1'b0;
                s_data <= 8'($urandom);
            end
        end
        burst_left--;
        @(negedge clk);
        s_valid <= 1'b1;
        s_data <= b;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    task automatic send_frame(input logic [15:0] len, input bit good_trailer);
        logic [1:0] rot;
        t_byte      b;
        rot = 2'($urandom_range(0, 3));
        repeat (3) push_byte(8'($urandom));
        b = 8'($urandom);
        b[5:4] = rot;
        push_byte(b);
        for (int i = 3; i >= 0; i--) begin
            b = 8'($urandom);
            b[3:0] = len[4*i +: 4];
            push_byte(b);
        end
        repeat (len) repeat (4) push_byte(8'($urandom));
        rot = rot + 2'(len);
        repeat (3) push_byte(8'($urandom));
        b = 8'($urandom);
        b[5:4] = good_trailer ? rot : 2'(rot + 2'($urandom_range(1, 3)));
        push_byte(b);
    endtask

    // receiver: random ready at first, then a long hold-off, then random stall patterns
    initial begin
        int mode;
        int span;
        int phase;
        phase = 0;
        wait (rst_n);
        repeat (60) begin
            @(negedge clk);
            m_ready <= 1'($urandom_range(0, 1));
        end
        repeat (400) begin
            @(negedge clk);
            m_ready <= 1'b0;
        end
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span) begin
                @(negedge clk);
                phase++;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 7) == 0);
                    default: m_ready <= (phase % 3 != 0);
                endcase
            end
        end
    end

    initial begin
        t_byte       directed [28];
        int          frames;
        logic [15:0] len;
        // rot 3, length 1, good trailer; then rot 2, length 0x0F00 header and one character group
        directed = '{
            8'h00, 8'hFF, 8'h00, 8'hFF, 8'hF0, 8'hF0, 8'hF0, 8'hF1,
            8'h00, 8'hFF, 8'h0F, 8'hF0,
            8'hFF, 8'h00, 8'hFF, 8'hCF,
            8'hFF, 8'h00, 8'hFF, 8'h20, 8'h00, 8'hFF, 8'h00, 8'hF0,
            8'h00, 8'hFF, 8'h00, 8'h10
        };
        frames = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i]) push_byte(directed[i]);

        while (bytes_sent < 2000) begin
            frames++;
            if (frames == 15) begin
                len = 16'h0100 | 16'($urandom_range(0, 15));
            end else if ($urandom_range(0, 4) == 0) begin
                len = 16'h0000;
            end else begin
                len = 16'($urandom_range(1, 20));
            end
            send_frame(len, $urandom_range(0, 4) != 0);
            if (frames % 20 == 0) wait_for_results();
        end

        wait_for_results();
        repeat (12) @(posedge clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
